// ----- design/perspective_vertex_projection_top_assert.svh -----
// Assertion macros for the perspective vertex projection block.
`ifndef PERSPECTIVE_VERTEX_PROJECTION_TOP_ASSERT_SVH
`define PERSPECTIVE_VERTEX_PROJECTION_TOP_ASSERT_SVH

// same-cycle implication, sampled on the rising clock edge
`define PVP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define PVP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- design/pvp_pkg.sv -----
// Shared constants and types for the perspective vertex projection block.
package pvp_pkg;
   localparam int unsigned SCREEN_W_DEF = 512;
   localparam int unsigned SCREEN_H_DEF = 512;

   localparam int unsigned COORD_W = 16;            // Q8.8 coordinate
   localparam int unsigned DIFF_W  = COORD_W + 1;   // vertex minus camera
   localparam int unsigned COEF_W  = 16;            // Q2.14 coefficient
   localparam int unsigned PROD_W  = DIFF_W + COEF_W;
   localparam int unsigned T_W     = 35;            // rotated coordinate
   localparam int unsigned FOCAL_W = 12;
   localparam int unsigned HALF_W  = 13;            // signed half screen size
   localparam int unsigned NUM_W   = 48;            // projection numerator
   localparam int unsigned QBITS   = 17;            // quotient magnitude bits
   localparam int unsigned DIV_LAT = QBITS + 2;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 48;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ROT_COL0 = 3'd0,
      CSR_ROT_COL1 = 3'd1,
      CSR_ROT_COL2 = 3'd2,
      CSR_CAM_X    = 3'd3,
      CSR_CAM_Y    = 3'd4,
      CSR_CAM_Z    = 3'd5,
      CSR_FOCAL    = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] value;
      logic                      sat;
   } proj_type;
endpackage

// ----- design/perspective_vertex_projection_top.sv -----
// Top level of the pinhole perspective vertex projection pipeline.
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+---------------------------------------
//  req     | in  | req_tvalid/tready    | tdata: vx[15:0] vy[31:16] vz[47:32]
//  rsp     | out | rsp_tvalid/tready    | tdata: px[15:0] py[31:16] clipped[32]
//  csr     | in  | csr_wr_en            | csr_index, csr_wdata
//
//  One vertex per cycle sustained while the output is not held; the path is 5 arithmetic
//  stages, a 19-stage bit-per-stage divider and one output register.
//  The whole pipeline moves on one enable: it holds when a result sits in the
//  output register and rsp_tready is low, and runs otherwise.
//  Reset (synchronous) clears valid bits and loads the CSR reset values.
module perspective_vertex_projection_top
   import pvp_pkg::*;
#(
   parameter int unsigned SCREEN_W = SCREEN_W_DEF,
   parameter int unsigned SCREEN_H = SCREEN_H_DEF
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [47:0]           req_tdata,   // vx, vy, vz
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [39:0]           rsp_tdata,   // px, py, clipped, zero pad
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);
   localparam logic signed [HALF_W-1:0]  HALF_X = HALF_W'(SCREEN_W / 2);
   localparam logic signed [HALF_W-1:0]  HALF_Y = HALF_W'(SCREEN_H / 2);
   localparam logic signed [COORD_W-1:0] CTR_X  = COORD_W'(SCREEN_W / 2);
   localparam logic signed [COORD_W-1:0] CTR_Y  = COORD_W'(SCREEN_H / 2);
   localparam int unsigned LAT = 5 + DIV_LAT + 1;

   // ---------------- configuration registers ----------------
   logic [CSR_DATA_W-1:0]     rot_ff [3];
   logic signed [COORD_W-1:0] cam_ff [3];
   logic [FOCAL_W-1:0]        focal_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rot_ff[0] <= 48'h0000_0000_4000;
         rot_ff[1] <= 48'h0000_4000_0000;
         rot_ff[2] <= 48'h4000_0000_0000;
         cam_ff[0] <= '0;
         cam_ff[1] <= '0;
         cam_ff[2] <= -16'sd768;
         focal_ff  <= FOCAL_W'(250);
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_ROT_COL0: rot_ff[0] <= csr_wdata;
            CSR_ROT_COL1: rot_ff[1] <= csr_wdata;
            CSR_ROT_COL2: rot_ff[2] <= csr_wdata;
            CSR_CAM_X:    cam_ff[0] <= signed'(csr_wdata[COORD_W-1:0]);
            CSR_CAM_Y:    cam_ff[1] <= signed'(csr_wdata[COORD_W-1:0]);
            CSR_CAM_Z:    cam_ff[2] <= signed'(csr_wdata[COORD_W-1:0]);
            CSR_FOCAL:    focal_ff  <= csr_wdata[FOCAL_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------- global stage enable ----------------
   logic           ce;
   logic [LAT-1:0] vld_ff;
   logic [LAT-1:0] vld_in;

   assign ce         = !vld_ff[LAT-1] || rsp_tready;
   assign req_tready = ce;
   assign rsp_tvalid = vld_ff[LAT-1];
   assign vld_in     = {vld_ff[LAT-2:0], req_tvalid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (ce) begin
         vld_ff <= vld_in;
      end
   end

   // ---------------- S1: subtract camera ----------------
   logic signed [DIFF_W-1:0] d_ff [3];
   always_ff @(posedge clock) begin
      if (ce) begin
         for (int k = 0; k < 3; k++) begin
            d_ff[k] <= DIFF_W'(signed'(req_tdata[k*COORD_W +: COORD_W]))
                       - DIFF_W'(cam_ff[k]);
         end
      end
   end

   // ---------------- S2: nine coefficient products ----------------
   // p_ff[3*i+k] = element i of column k times d[k]
   logic signed [PROD_W-1:0] p_ff [9];
   always_ff @(posedge clock) begin
      if (ce) begin
         for (int i = 0; i < 3; i++) begin
            for (int k = 0; k < 3; k++) begin
               p_ff[3*i+k] <= PROD_W'(signed'(rot_ff[k][i*COEF_W +: COEF_W]) * d_ff[k]);
            end
         end
      end
   end

   // ---------------- S3: row sums ----------------
   logic signed [T_W-1:0] t_ff [3];
   always_ff @(posedge clock) begin
      if (ce) begin
         for (int i = 0; i < 3; i++) begin
            t_ff[i] <= T_W'(p_ff[3*i]) + T_W'(p_ff[3*i+1]) + T_W'(p_ff[3*i+2]);
         end
      end
   end

   // ---------------- S4: focal and center products ----------------
   logic signed [NUM_W-1:0] fx_ff, fy_ff, hx_ff, hy_ff;
   logic signed [T_W-1:0]   tz4_ff;
   logic                    xpos_ff, xneg_ff, ypos_ff, yneg_ff, fnz_ff;
   logic signed [FOCAL_W:0] focal_s;
   assign focal_s = signed'({1'b0, focal_ff});

   always_ff @(posedge clock) begin
      if (ce) begin
         fx_ff   <= NUM_W'(focal_s * t_ff[0]);
         fy_ff   <= NUM_W'(focal_s * t_ff[1]);
         hx_ff   <= NUM_W'(HALF_X * t_ff[2]);
         hy_ff   <= NUM_W'(HALF_Y * t_ff[2]);
         tz4_ff  <= t_ff[2];
         xpos_ff <= !t_ff[0][T_W-1] && (t_ff[0] != '0);
         xneg_ff <= t_ff[0][T_W-1];
         ypos_ff <= !t_ff[1][T_W-1] && (t_ff[1] != '0);
         yneg_ff <= t_ff[1][T_W-1];
         fnz_ff  <= focal_ff != '0;
      end
   end

   // ---------------- S5: numerators and zero-depth result ----------------
   logic signed [NUM_W-1:0] nx_ff, ny_ff;
   logic signed [T_W-1:0]   tz5_ff;
   proj_type                zx_in, zy_in;
   logic                    zero4;

   assign zero4 = tz4_ff == '0;

   always_comb begin
      // depth zero: pin to the edge the lateral offset points at
      zx_in.sat   = zero4;
      zy_in.sat   = zero4;
      zx_in.value = (fnz_ff && xpos_ff) ? 16'sh7fff :
                    (fnz_ff && xneg_ff) ? 16'sh8000 : CTR_X;
      zy_in.value = (fnz_ff && ypos_ff) ? 16'sh7fff :
                    (fnz_ff && yneg_ff) ? 16'sh8000 : CTR_Y;
   end

   // zero-depth results ride alongside the divider
   proj_type zx_ff [DIV_LAT+1];
   proj_type zy_ff [DIV_LAT+1];

   always_ff @(posedge clock) begin
      if (ce) begin
         nx_ff     <= fx_ff + hx_ff;
         ny_ff     <= fy_ff + hy_ff;
         tz5_ff    <= tz4_ff;
         zx_ff[0]  <= zx_in;
         zy_ff[0]  <= zy_in;
         for (int s = 1; s <= DIV_LAT; s++) begin
            zx_ff[s] <= zx_ff[s-1];
            zy_ff[s] <= zy_ff[s-1];
         end
      end
   end

   // ---------------- divider lanes ----------------
   proj_type qx, qy;

   pvp_div u_div_x (
      .clock (clock),
      .ce    (ce),
      .num   (nx_ff),
      .den   (tz5_ff),
      .quo   (qx)
   );

   pvp_div u_div_y (
      .clock (clock),
      .ce    (ce),
      .num   (ny_ff),
      .den   (tz5_ff),
      .quo   (qy)
   );

   // ---------------- output register ----------------
   proj_type px_ff, py_ff;
   logic     clip_ff;
   logic     zero_out;
   // sat on the zero-depth path means the depth was zero
   assign zero_out = zx_ff[DIV_LAT].sat;

   always_ff @(posedge clock) begin
      if (ce) begin
         px_ff   <= zero_out ? zx_ff[DIV_LAT] : qx;
         py_ff   <= zero_out ? zy_ff[DIV_LAT] : qy;
         clip_ff <= zero_out || qx.sat || qy.sat;
      end
   end

   assign rsp_tdata = {7'd0, clip_ff, py_ff.value, px_ff.value};

   // ---------------- assertions ----------------
`include "perspective_vertex_projection_top_assert.svh"

   `PVP_ASSERT_NOW(a_accept_moves, clock, reset, req_tvalid && req_tready, (!rsp_tvalid || rsp_tready), "input taken while pipeline held")
   `PVP_ASSERT_NEXT(a_hold_valid, clock, reset, !ce, vld_ff == $past(vld_ff), "valid bits moved during stall")
   `PVP_ASSERT_NEXT(a_zero_clips, clock, reset, ce && zero_out, clip_ff, "zero depth not flagged")
endmodule

// ----- design/pvp_div.sv -----
// Pipelined signed divider with 16-bit saturation, one quotient bit per stage.
module pvp_div
   import pvp_pkg::*;
(
   input  logic                    clock,
   input  logic                    ce,
   input  logic signed [NUM_W-1:0] num,
   input  logic signed [T_W-1:0]   den,
   output proj_type                quo
);
   localparam int unsigned CMP_W = T_W + QBITS;

   logic [NUM_W-1:0] rem_ff [QBITS+1];
   logic [T_W-1:0]   dmag_ff [QBITS+1];
   logic [QBITS-1:0] q_ff [QBITS+1];
   logic             neg_ff [QBITS+1];
   logic             ovf_ff [QBITS+1];
   proj_type         quo_ff;
   proj_type         quo_in;

   logic [NUM_W-1:0] nmag;
   logic [T_W-1:0]   dmag;

   assign nmag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
   assign dmag = den[T_W-1] ? T_W'(-den) : T_W'(den);

   // stage A: magnitudes, sign and the early out-of-range test
   always_ff @(posedge clock) begin
      if (ce) begin
         rem_ff[0]  <= nmag;
         dmag_ff[0] <= dmag;
         q_ff[0]    <= '0;
         neg_ff[0]  <= num[NUM_W-1] ^ den[T_W-1];
         ovf_ff[0]  <= CMP_W'(nmag) >= {dmag, QBITS'(0)};
      end
   end

   for (genvar j = 1; j <= QBITS; j++) begin : g_step
      localparam int unsigned B = QBITS - j;
      logic [CMP_W-1:0] trial;
      logic             take;
      assign trial = CMP_W'(dmag_ff[j-1]) << B;
      assign take  = CMP_W'(rem_ff[j-1]) >= trial;
      always_ff @(posedge clock) begin
         if (ce) begin
            rem_ff[j]  <= take ? NUM_W'(CMP_W'(rem_ff[j-1]) - trial) : rem_ff[j-1];
            dmag_ff[j] <= dmag_ff[j-1];
            q_ff[j]    <= {q_ff[j-1][QBITS-2:0], take};
            neg_ff[j]  <= neg_ff[j-1];
            ovf_ff[j]  <= ovf_ff[j-1];
         end
      end
   end

   logic [QBITS-1:0] qneg;
   logic             big;
   assign qneg = QBITS'(-q_ff[QBITS]);
   // negative side reaches one step further
   assign big = ovf_ff[QBITS] ||
                (neg_ff[QBITS] ? (q_ff[QBITS] > QBITS'(32768))
                               : (q_ff[QBITS] > QBITS'(32767)));

   always_comb begin
      quo_in.sat = big;
      if (big) begin
         quo_in.value = neg_ff[QBITS] ? 16'sh8000 : 16'sh7fff;
      end else begin
         quo_in.value = neg_ff[QBITS] ? signed'(qneg[COORD_W-1:0])
                                      : signed'(q_ff[QBITS][COORD_W-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         quo_ff <= quo_in;
      end
   end

   assign quo = quo_ff;
endmodule
